@@ rtl/polyphase_symbol_timing_recovery_macros.svh @@
// Assertion macros for the polyphase symbol timing recovery block
`ifndef POLYPHASE_SYMBOL_TIMING_RECOVERY_MACROS_SVH
`define POLYPHASE_SYMBOL_TIMING_RECOVERY_MACROS_SVH
`ifndef SYNTHESIS
`define PSTR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PSTR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PSTR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PSTR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/pstr_pkg.sv @@
// Types and codes shared by the polyphase symbol timing recovery block
`default_nettype none
package pstr_pkg;
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_LOAD_MF = 2'd1;
    localparam logic [1:0] OP_LOAD_DF = 2'd2;
    localparam logic [1:0] KIND_SYMBOL = 2'd0;
    localparam logic [1:0] KIND_ERASED = 2'd1;
    localparam logic [1:0] KIND_RETRACT = 2'd2;
    localparam logic CFG_UNLOCKED = 1'b0;
    localparam logic CFG_LOCKED = 1'b1;
    localparam int ThrWidth = 10;
    localparam int SymWidth = 24;
    typedef struct packed {
        logic [1:0] opcode;
        logic signed [15:0] sample;
        logic [5:0] coef_phase;
        logic [4:0] coef_tap;
        logic signed [15:0] coef_value;
        logic locked;
    } in_item_t;
    typedef struct packed {
        logic [1:0] kind;
        logic signed [23:0] symbol;
        logic [5:0] sync_phase;
    } out_item_t;
    typedef struct packed {
        logic index;
        logic [ThrWidth-1:0] data;
    } cfg_item_t;
endpackage
`default_nettype wire

@@ rtl/pstr_stream_if.sv @@
// Valid/ready channel interfaces for items and configuration writes
`default_nettype none
interface pstr_in_if;
    logic valid;
    logic ready;
    pstr_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pstr_out_if;
    logic valid;
    logic ready;
    pstr_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pstr_cfg_if;
    logic valid;
    logic ready;
    pstr_pkg::cfg_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/polyphase_symbol_timing_recovery.sv @@
// Top level of the polyphase filter-bank symbol timing recovery block
//
// A sample item on a symbol slot is walked by two multipliers, one per coefficient memory,
// over the sample window, one tap per cycle, through the states S_MAC, S_DRAIN and S_EMIT
// into the output register. The result waits in the output register, and the input is held
// off until it leaves. An error slot that wraps the phase emits an item. There is no
// clearing pass after reset.
`default_nettype none
`include "polyphase_symbol_timing_recovery_macros.svh"
module polyphase_symbol_timing_recovery #(
    parameter int PHASES = 40,
    parameter int TAPS = 31
) (
    input wire logic clk,
    input wire logic rst_n,
    pstr_in_if.sink in_ch,
    pstr_out_if.source out_ch,
    pstr_cfg_if.sink cfg
);
    localparam int PW = $clog2(PHASES);
    localparam int TW = $clog2(TAPS);
    localparam int AW = $clog2(PHASES * TAPS);
    localparam int DEPTH = PHASES * TAPS;
    localparam int AccW = 32 + $clog2(TAPS) + 1;

    typedef enum logic [1:0] {S_IDLE, S_MAC, S_DRAIN, S_EMIT} state_t;

    state_t state_reg;
    logic signed [15:0] mf_mem [DEPTH];
    logic signed [15:0] df_mem [DEPTH];
    logic signed [15:0] win_reg [TAPS];
    logic signed [15:0] mf_rd_reg, df_rd_reg, smp_rd_reg;
    logic [AW-1:0] base_reg;
    logic [TW:0] tap_reg;
    logic rd_vld_reg;
    logic signed [AccW-1:0] macc_reg, dacc_reg;
    logic [PW-1:0] phase_reg;
    logic half_reg;
    logic signed [11:0] cnt_reg;
    logic neg_reg;
    logic [1:0] dsign_reg;
    logic [pstr_pkg::ThrWidth-1:0] thr_unl_reg, thr_lck_reg;
    logic out_valid_reg;
    pstr_pkg::out_item_t out_reg;

    pstr_pkg::in_item_t it;
    logic in_acc;
    logic [AW-1:0] ld_addr, rd_addr;
    logic ld_ok;
    logic signed [31:0] mprod, dprod;
    logic signed [AccW-1:0] msum;
    logic signed [AccW-1:0] rnd;
    logic signed [AccW-1:0] shr;
    logic signed [pstr_pkg::SymWidth-1:0] sym;
    logic signed [12:0] cnt_step;
    logic signed [11:0] cnt_next;
    logic signed [12:0] thr;
    logic step_up, step_dn;
    logic move_up, move_dn;
    logic wrap_up, wrap_dn;
    logic [PW-1:0] ph_up, ph_dn;

    assign it = in_ch.data;
    assign in_ch.ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign in_acc = in_ch.valid && in_ch.ready;
    assign cfg.ready = 1'b1;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data = out_reg;

    assign ld_addr = AW'(it.coef_phase * TAPS + it.coef_tap);
    assign ld_ok = (32'(it.coef_phase) < PHASES) && (32'(it.coef_tap) < TAPS);
    assign rd_addr = base_reg + AW'(tap_reg);

    assign mprod = smp_rd_reg * mf_rd_reg;
    assign dprod = smp_rd_reg * df_rd_reg;

    assign msum = macc_reg;
    assign rnd = msum + AccW'(8192);
    assign shr = rnd >>> 14;
    always_comb
    begin
        if (shr > AccW'(8388607))
            sym = 24'sh7FFFFF;
        else if (shr < -AccW'(8388608))
            sym = 24'sh800000;
        else
            sym = shr[pstr_pkg::SymWidth-1:0];
    end

    always_comb
    begin
        step_up = (dsign_reg == 2'd1 && !neg_reg) || (dsign_reg == 2'd2 && neg_reg);
        step_dn = (dsign_reg == 2'd2 && !neg_reg) || (dsign_reg == 2'd1 && neg_reg);
        cnt_next = cnt_reg;
        if (step_up && cnt_reg != 12'sh7FF)
            cnt_next = cnt_reg + 12'sd1;
        if (step_dn && cnt_reg != 12'sh800)
            cnt_next = cnt_reg - 12'sd1;
        cnt_step = 13'(cnt_next);
        thr = it.locked ? 13'(thr_lck_reg) : 13'(thr_unl_reg);
        ph_up = (32'(phase_reg) == PHASES - 1) ? '0 : phase_reg + PW'(1);
        ph_dn = (phase_reg == '0) ? PW'(PHASES - 1) : phase_reg - PW'(1);
        move_up = cnt_step > thr;
        move_dn = !move_up && (cnt_step < -thr);
        wrap_up = move_up && (ph_up == '0);
        wrap_dn = move_dn && (32'(ph_dn) == PHASES - 1);
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && ld_ok && it.opcode == pstr_pkg::OP_LOAD_MF)
            mf_mem[ld_addr] <= it.coef_value;
        if (in_acc && ld_ok && it.opcode == pstr_pkg::OP_LOAD_DF)
            df_mem[ld_addr] <= it.coef_value;
        mf_rd_reg <= mf_mem[rd_addr];
        df_rd_reg <= df_mem[rd_addr];
        smp_rd_reg <= win_reg[tap_reg[TW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int i = 0; i < TAPS; i++)
                win_reg[i] <= '0;
            base_reg <= '0;
            tap_reg <= '0;
            rd_vld_reg <= 1'b0;
            macc_reg <= '0;
            dacc_reg <= '0;
            phase_reg <= PW'(10 % PHASES);
            half_reg <= 1'b1;
            cnt_reg <= '0;
            neg_reg <= 1'b0;
            dsign_reg <= 2'd0;
            thr_unl_reg <= 10'd10;
            thr_lck_reg <= 10'd80;
            out_valid_reg <= 1'b0;
            out_reg <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                if (cfg.data.index == pstr_pkg::CFG_UNLOCKED)
                    thr_unl_reg <= cfg.data.data;
                else
                    thr_lck_reg <= cfg.data.data;
            end
            if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && it.opcode == pstr_pkg::OP_SAMPLE)
                    begin
                        for (int i = 0; i < TAPS - 1; i++)
                            win_reg[i] <= win_reg[i + 1];
                        win_reg[TAPS - 1] <= it.sample;
                        if (!half_reg)
                        begin
                            half_reg <= 1'b1;
                            base_reg <= AW'(phase_reg * TAPS);
                            tap_reg <= '0;
                            macc_reg <= '0;
                            dacc_reg <= '0;
                            rd_vld_reg <= 1'b0;
                            state_reg <= S_MAC;
                        end
                        else
                        begin
                            half_reg <= wrap_up || wrap_dn;
                            cnt_reg <= (move_up || move_dn) ? 12'sd0 : cnt_next;
                            if (move_up)
                                phase_reg <= ph_up;
                            else if (move_dn)
                                phase_reg <= ph_dn;
                            if (wrap_up)
                            begin
                                out_reg <= '{pstr_pkg::KIND_ERASED, '0, 6'(ph_up)};
                                out_valid_reg <= 1'b1;
                            end
                            else if (wrap_dn)
                            begin
                                out_reg <= '{pstr_pkg::KIND_RETRACT, '0, 6'(ph_dn)};
                                out_valid_reg <= 1'b1;
                            end
                        end
                    end
                end
                S_MAC:
                begin
                    rd_vld_reg <= 1'b1;
                    if (rd_vld_reg)
                    begin
                        macc_reg <= macc_reg + AccW'(mprod);
                        dacc_reg <= dacc_reg + AccW'(dprod);
                    end
                    if (32'(tap_reg) == TAPS - 1)
                        state_reg <= S_DRAIN;
                    else
                        tap_reg <= tap_reg + 1'b1;
                end
                S_DRAIN:
                begin
                    macc_reg <= macc_reg + AccW'(mprod);
                    dacc_reg <= dacc_reg + AccW'(dprod);
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    neg_reg <= macc_reg < 0;
                    dsign_reg <= (dacc_reg > 0) ? 2'd1 : ((dacc_reg < 0) ? 2'd2 : 2'd0);
                    out_reg <= '{pstr_pkg::KIND_SYMBOL, sym, 6'(phase_reg)};
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `PSTR_ASSERT_IMPL(a_busy_not_ready, clk, rst_n, state_reg != S_IDLE, !in_ch.ready)
    `PSTR_ASSERT_IMPL(a_phase_range, clk, rst_n, 1'b1, 32'(phase_reg) < PHASES)
    `PSTR_ASSERT_NEXT(a_emit_out, clk, rst_n, state_reg == S_EMIT, out_valid_reg)
    `PSTR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_reg && !out_ch.ready, $stable(out_reg))
endmodule
`default_nettype wire
